// ----- hdl/bxos_pkg.sv -----
// ---------------------------------------------------------------------------
// bxos_pkg: shared types and codes for the binary trie XOR order stats block
// Holds the operation and status codes and the command and status structs
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
package bxos_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_ERASE  = 3'd1;
	localparam logic [2:0] OP_COUNT  = 3'd2;
	localparam logic [2:0] OP_KMAX   = 3'd3;
	localparam logic [2:0] OP_KMIN   = 3'd4;
	localparam logic [2:0] OP_BELOW  = 3'd5;

	// Status codes carried on the output tuser.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANK = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	// Stream word widths.
	localparam int IN_W  = 112;
	localparam int OUT_W = 80;

	// What the datapath asks the controller to do next.
	typedef enum logic [2:0] {
		ACT_STAY = 3'd0,
		ACT_LOAD = 3'd1,
		ACT_PEEK = 3'd2,
		ACT_SUM  = 3'd3,
		ACT_FIN  = 3'd4
	} act_t;

	typedef struct packed {
		logic start;
		logic step;
		logic latch;
		logic peek;
		logic sum;
		logic emit;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/binary_trie_xor_order_stats.sv -----
// ---------------------------------------------------------------------------
// binary_trie_xor_order_stats: multiset of keys in a binary trie
// Insert, erase, prefix count, XOR k-th max and min, and XOR count below a
// bound, over a node store with one write and one registered read port.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Word                            Side band
//  s_*       in         key, amount, rank, skip, bound  op
//  m_*       out        value, tally, total             status
//
// One request is worked on at a time. Each node fetched from the store takes
// an address step and then a latch step, since the node store has a single
// read port with registered data. Insert and erase walk the key twice, and
// the k-th and count-below queries may add a peek or sum step per level.
// A finished result waits in the output register while the next request is
// taken; a request that finishes while that register is still full waits
// in the controller until m_tready frees it.
// Reset empties the trie at once: the root sits in flip-flops and every other
// node is written when it is allocated, so no clearing pass is needed.
module binary_trie_xor_order_stats #(
	parameter int KEY_BITS   = 32,
	parameter int NODES      = 8192,
	parameter int TALLY_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0 up: key[31:0], amount[47:32], rank[71:48],
	// prefix_skip[77:72], bound[109:78], zero fill [111:110].
	input  logic [111:0] s_tdata,
	// Fields: op[2:0].
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0 up: value[31:0], tally[55:32], total[79:56].
	output logic [79:0] m_tdata,
	// Fields: status[1:0].
	output logic [1:0]  m_tuser
);

	bxos_pkg::cmd_t  cmd;
	bxos_pkg::stat_t sts;

	logic [31:0] value;
	logic [23:0] tally, total;

	// The controller sequences the walk; the datapath holds every register but the controller state.
	bxos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	bxos_datapath #(
		.KEY_BITS  (KEY_BITS),
		.NODES     (NODES),
		.TALLY_BITS(TALLY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (s_tuser),
		.key        (s_tdata[31:0]),
		.amount     (s_tdata[47:32]),
		.rank       (s_tdata[71:48]),
		.prefix_skip(s_tdata[77:72]),
		.bound      (s_tdata[109:78]),
		.value      (value),
		.tally      (tally),
		.total      (total),
		.status     (m_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready)
	);

	assign m_tdata = {total, tally, value};

endmodule

// ----- hdl/bxos_ram.sv -----
// ---------------------------------------------------------------------------
// bxos_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bxos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/bxos_datapath.sv -----
// ---------------------------------------------------------------------------
// bxos_datapath: trie walk datapath
// Holds the request, the current node, the root node, the allocation pointer
// and the node store, and decides each walk step for the controller.
// ---------------------------------------------------------------------------
module bxos_datapath #(
	parameter int KEY_BITS   = 32,
	parameter int NODES      = 8192,
	parameter int TALLY_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bxos_pkg::cmd_t     cmd,
	output bxos_pkg::stat_t    sts,
	input  logic [2:0]         op,
	input  logic [31:0]        key,
	input  logic [15:0]        amount,
	input  logic [23:0]        rank,
	input  logic [5:0]         prefix_skip,
	input  logic [31:0]        bound,
	output logic [31:0]        value,
	output logic [23:0]        tally,
	output logic [23:0]        total,
	output logic [1:0]         status,
	output logic               out_valid,
	input  logic               out_ready
);

	localparam int AW  = $clog2(NODES);
	localparam int LVW = $clog2(KEY_BITS + 1);
	localparam int TW  = TALLY_BITS;
	localparam int CW  = ((TW > 16) ? TW : 16) + 1;
	localparam int RKW = (TW > 24) ? TW : 24;
	localparam int DW  = TW + 2 * AW;
	localparam int FW  = AW + 2;

	localparam logic [CW-1:0] TMAX = {{(CW - TW){1'b0}}, {TW{1'b1}}};

	// Request registers.
	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [15:0]         amount_q;
	logic [23:0]         rank_q;
	logic [5:0]          skip_q;

	// Walk registers.
	logic [KEY_BITS-1:0] key_sh_q, bnd_sh_q, res_q;
	logic                pass_q;
	logic [LVW-1:0]      lvl_q;
	logic [AW-1:0]       cur_addr_q, cur_c0_q, cur_c1_q, ld_addr_q, alt_q;
	logic [TW-1:0]       cur_tally_q, rem_q, acc_q, rmv_q;

	// Root node and allocation pointer.
	logic [TW-1:0]       root_tally_q;
	logic [AW-1:0]       root_c0_q, root_c1_q;
	logic [AW:0]         next_free_q;

	// Finished result.
	logic [KEY_BITS-1:0] fin_value_q;
	logic [TW-1:0]       fin_tally_q;
	logic [1:0]          fin_status_q;

	// Output register.
	logic [31:0]         value_q;
	logic [23:0]         tally_q, total_q;
	logic [1:0]          status_q;
	logic                out_valid_q;

	// Next values.
	logic [KEY_BITS-1:0] d_key_sh, d_bnd_sh, d_res, d_fin_value;
	logic                d_pass;
	logic [LVW-1:0]      d_lvl;
	logic [AW-1:0]       d_cur_addr, d_cur_c0, d_cur_c1, d_ld_addr, d_alt;
	logic [TW-1:0]       d_cur_tally, d_rem, d_acc, d_rmv, d_fin_tally;
	logic [TW-1:0]       d_root_tally;
	logic [AW-1:0]       d_root_c0, d_root_c1;
	logic [AW:0]         d_next_free;
	logic [1:0]          d_fin_status;
	bxos_pkg::act_t      act;

	// Step decision helpers.
	logic                issue, adv, res_upd, res_bit, fin, restart, wr_cur;
	logic [AW-1:0]       ld_sel, wr_c0, wr_c1;
	logic [TW-1:0]       wr_t, fin_t, rd_t, newt, rmv_min, sum_t;
	logic [KEY_BITS-1:0] fin_v;
	logic [1:0]          fin_s;
	logic                bit_k, bit_v, want_max, pref, at_leaf, non_root, dead;
	logic                ovf, full, rank_fail;
	logic [AW-1:0]       cb, cnb, cp, ca, nxt, alloc, rd_c0, rd_c1;

	// Node store.
	logic                ram_wr_en, ram_rd_en;
	logic [AW-1:0]       ram_rd_addr;
	logic [DW-1:0]       ram_rd_data;

	bxos_ram #(
		.WIDTH(DW),
		.DEPTH(NODES)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(cur_addr_q),
		.wr_data({wr_t, wr_c1, wr_c0}),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	assign rd_t  = ram_rd_data[DW-1 -: TW];
	assign rd_c1 = ram_rd_data[2*AW-1 -: AW];
	assign rd_c0 = ram_rd_data[AW-1:0];

	assign bit_k     = key_sh_q[KEY_BITS-1];
	assign bit_v     = bnd_sh_q[KEY_BITS-1];
	assign want_max  = (op_q == bxos_pkg::OP_KMAX);
	assign pref      = want_max ? ~bit_k : bit_k;
	assign cb        = bit_k ? cur_c1_q : cur_c0_q;
	assign cnb       = bit_k ? cur_c0_q : cur_c1_q;
	assign cp        = pref ? cur_c1_q : cur_c0_q;
	assign ca        = pref ? cur_c0_q : cur_c1_q;
	assign nxt       = bit_v ? cnb : cb;
	assign at_leaf   = (lvl_q == '0);
	assign non_root  = (cur_addr_q != '0);
	assign dead      = non_root && (cur_tally_q == '0);
	assign alloc     = next_free_q[AW-1:0];
	assign newt      = cur_tally_q + TW'(amount_q);
	assign rmv_min   = (CW'(cur_tally_q) < CW'(amount_q)) ? cur_tally_q : TW'(amount_q);
	assign sum_t     = acc_q + rd_t;
	assign ovf       = (CW'(root_tally_q) + CW'(amount_q)) > TMAX;
	assign full      = (FW'(next_free_q) + FW'(lvl_q)) > FW'(NODES);
	assign rank_fail = RKW'(rank_q) >= RKW'(root_tally_q);

	always_comb begin
		d_key_sh     = key_sh_q;
		d_bnd_sh     = bnd_sh_q;
		d_res        = res_q;
		d_pass       = pass_q;
		d_lvl        = lvl_q;
		d_cur_addr   = cur_addr_q;
		d_cur_tally  = cur_tally_q;
		d_cur_c0     = cur_c0_q;
		d_cur_c1     = cur_c1_q;
		d_ld_addr    = ld_addr_q;
		d_alt        = alt_q;
		d_rem        = rem_q;
		d_acc        = acc_q;
		d_rmv        = rmv_q;
		d_root_tally = root_tally_q;
		d_root_c0    = root_c0_q;
		d_root_c1    = root_c1_q;
		d_next_free  = next_free_q;
		d_fin_value  = fin_value_q;
		d_fin_tally  = fin_tally_q;
		d_fin_status = fin_status_q;
		act          = bxos_pkg::ACT_STAY;
		issue        = 1'b0;
		ld_sel       = cb;
		adv          = 1'b0;
		res_upd      = 1'b0;
		res_bit      = 1'b0;
		fin          = 1'b0;
		fin_t        = '0;
		fin_s        = bxos_pkg::ST_OK;
		fin_v        = '0;
		restart      = 1'b0;
		wr_cur       = 1'b0;
		wr_t         = cur_tally_q;
		wr_c0        = cur_c0_q;
		wr_c1        = cur_c1_q;

		if (cmd.start) begin
			d_key_sh    = KEY_BITS'(key);
			d_bnd_sh    = KEY_BITS'(bound);
			d_res       = '0;
			d_acc       = '0;
			d_pass      = 1'b0;
			d_lvl       = LVW'(KEY_BITS);
			d_cur_addr  = '0;
			d_cur_tally = root_tally_q;
			d_cur_c0    = root_c0_q;
			d_cur_c1    = root_c1_q;
		end else if (cmd.latch) begin
			d_cur_addr  = ld_addr_q;
			d_cur_tally = rd_t;
			d_cur_c0    = rd_c0;
			d_cur_c1    = rd_c1;
		end else if (cmd.step) begin
			unique case (op_q) inside
				bxos_pkg::OP_INSERT: begin
					if (!pass_q) begin
						if (amount_q == '0) begin
							fin = 1'b1;
						end else if (ovf) begin
							fin   = 1'b1;
							fin_s = bxos_pkg::ST_OVF;
						end else if (at_leaf || cb == '0) begin
							if (full) begin
								fin   = 1'b1;
								fin_s = bxos_pkg::ST_FULL;
							end else begin
								restart = 1'b1;
							end
						end else begin
							issue = 1'b1;
							adv   = 1'b1;
							act   = bxos_pkg::ACT_LOAD;
						end
					end else begin
						wr_cur = 1'b1;
						wr_t   = newt;
						if (at_leaf) begin
							fin   = 1'b1;
							fin_t = newt;
						end else if (cb == '0) begin
							// Missing child: link a fresh empty node and step into it.
							if (bit_k) begin
								wr_c1 = alloc;
							end else begin
								wr_c0 = alloc;
							end
							d_next_free = next_free_q + 1'b1;
							d_cur_addr  = alloc;
							d_cur_tally = '0;
							d_cur_c0    = '0;
							d_cur_c1    = '0;
							adv         = 1'b1;
						end else begin
							issue = 1'b1;
							adv   = 1'b1;
							act   = bxos_pkg::ACT_LOAD;
						end
					end
				end
				bxos_pkg::OP_ERASE: begin
					if (!pass_q) begin
						if (dead) begin
							fin = 1'b1;
						end else if (at_leaf) begin
							d_rmv   = rmv_min;
							restart = 1'b1;
						end else if (cb == '0) begin
							fin = 1'b1;
						end else begin
							issue = 1'b1;
							adv   = 1'b1;
							act   = bxos_pkg::ACT_LOAD;
						end
					end else begin
						wr_cur = 1'b1;
						wr_t   = cur_tally_q - rmv_q;
						if (at_leaf) begin
							fin   = 1'b1;
							fin_t = rmv_q;
						end else begin
							issue = 1'b1;
							adv   = 1'b1;
							act   = bxos_pkg::ACT_LOAD;
						end
					end
				end
				bxos_pkg::OP_COUNT: begin
					if (dead) begin
						fin = 1'b1;
					end else if (7'(lvl_q) <= {1'b0, skip_q}) begin
						fin   = 1'b1;
						fin_t = cur_tally_q;
					end else if (cb == '0) begin
						fin = 1'b1;
					end else begin
						issue = 1'b1;
						adv   = 1'b1;
						act   = bxos_pkg::ACT_LOAD;
					end
				end
				bxos_pkg::OP_KMAX, bxos_pkg::OP_KMIN: begin
					if (!pass_q) begin
						if (rank_fail) begin
							fin   = 1'b1;
							fin_s = bxos_pkg::ST_RANK;
						end else begin
							d_pass = 1'b1;
							d_rem  = TW'(rank_q);
						end
					end else if (at_leaf) begin
						fin   = 1'b1;
						fin_v = res_q;
					end else if (cp == '0) begin
						// Preferred side is empty, so the rank lies on the other side.
						res_upd = 1'b1;
						res_bit = ~want_max;
						adv     = 1'b1;
						issue   = 1'b1;
						ld_sel  = ca;
						act     = bxos_pkg::ACT_LOAD;
					end else begin
						issue  = 1'b1;
						ld_sel = cp;
						d_alt  = ca;
						act    = bxos_pkg::ACT_PEEK;
					end
				end
				bxos_pkg::OP_BELOW: begin
					if (at_leaf || dead) begin
						fin   = 1'b1;
						fin_t = acc_q;
					end else if (bit_v && cb != '0) begin
						issue = 1'b1;
						d_alt = nxt;
						act   = bxos_pkg::ACT_SUM;
					end else if (nxt == '0) begin
						fin   = 1'b1;
						fin_t = acc_q;
					end else begin
						issue  = 1'b1;
						ld_sel = nxt;
						adv    = 1'b1;
						act    = bxos_pkg::ACT_LOAD;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end else if (cmd.peek) begin
			d_cur_addr  = ld_addr_q;
			d_cur_tally = rd_t;
			d_cur_c0    = rd_c0;
			d_cur_c1    = rd_c1;
			res_upd     = 1'b1;
			adv         = 1'b1;
			if (rd_t > rem_q) begin
				res_bit = want_max;
			end else begin
				d_rem   = rem_q - rd_t;
				res_bit = ~want_max;
				issue   = 1'b1;
				ld_sel  = alt_q;
				act     = bxos_pkg::ACT_LOAD;
			end
		end else if (cmd.sum) begin
			d_acc = sum_t;
			if (alt_q == '0) begin
				fin   = 1'b1;
				fin_t = sum_t;
			end else begin
				issue  = 1'b1;
				ld_sel = alt_q;
				adv    = 1'b1;
				act    = bxos_pkg::ACT_LOAD;
			end
		end

		if (issue) begin
			d_ld_addr = ld_sel;
		end
		if (adv) begin
			d_key_sh = key_sh_q << 1;
			d_bnd_sh = bnd_sh_q << 1;
			d_lvl    = lvl_q - 1'b1;
		end
		if (res_upd) begin
			d_res = (res_q << 1) | KEY_BITS'(res_bit);
		end
		if (restart) begin
			d_pass      = 1'b1;
			d_lvl       = LVW'(KEY_BITS);
			d_key_sh    = key_q;
			d_cur_addr  = '0;
			d_cur_tally = root_tally_q;
			d_cur_c0    = root_c0_q;
			d_cur_c1    = root_c1_q;
		end
		if (wr_cur && !non_root) begin
			d_root_tally = wr_t;
			d_root_c0    = wr_c0;
			d_root_c1    = wr_c1;
		end
		if (fin) begin
			act          = bxos_pkg::ACT_FIN;
			d_fin_tally  = fin_t;
			d_fin_status = fin_s;
			d_fin_value  = fin_v;
		end
	end

	assign ram_wr_en   = wr_cur && non_root;
	assign ram_rd_en   = issue;
	assign ram_rd_addr = ld_sel;

	assign sts.act      = act;
	assign sts.out_free = !out_valid_q || out_ready;

	// Request, walk, finished-result and output registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q     <= op;
			key_q    <= KEY_BITS'(key);
			amount_q <= amount;
			rank_q   <= rank;
			skip_q   <= prefix_skip;
		end
		key_sh_q     <= d_key_sh;
		bnd_sh_q     <= d_bnd_sh;
		res_q        <= d_res;
		pass_q       <= d_pass;
		lvl_q        <= d_lvl;
		cur_addr_q   <= d_cur_addr;
		cur_tally_q  <= d_cur_tally;
		cur_c0_q     <= d_cur_c0;
		cur_c1_q     <= d_cur_c1;
		ld_addr_q    <= d_ld_addr;
		alt_q        <= d_alt;
		rem_q        <= d_rem;
		acc_q        <= d_acc;
		rmv_q        <= d_rmv;
		fin_value_q  <= d_fin_value;
		fin_tally_q  <= d_fin_tally;
		fin_status_q <= d_fin_status;
		if (cmd.emit) begin
			value_q  <= 32'(fin_value_q);
			tally_q  <= 24'(fin_tally_q);
			total_q  <= 24'(root_tally_q);
			status_q <= fin_status_q;
		end
	end

	// Root node, allocation pointer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_tally_q <= '0;
			root_c0_q    <= '0;
			root_c1_q    <= '0;
			next_free_q  <= (AW + 1)'(1);
			out_valid_q  <= 1'b0;
		end else begin
			root_tally_q <= d_root_tally;
			root_c0_q    <= d_root_c0;
			root_c1_q    <= d_root_c1;
			next_free_q  <= d_next_free;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign value     = value_q;
	assign tally     = tally_q;
	assign total     = total_q;
	assign status    = status_q;
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/bxos_ctrl.sv -----
// ---------------------------------------------------------------------------
// bxos_ctrl: request sequencer
// Steps the datapath through walk, fetch, peek and sum cycles and hands the
// finished result to the output register.
// ---------------------------------------------------------------------------
module bxos_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output bxos_pkg::cmd_t  cmd,
	input  bxos_pkg::stat_t sts
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_STEP  = 6'b000010,
		S_FETCH = 6'b000100,
		S_PEEK  = 6'b001000,
		S_SUM   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				unique case (sts.act)
					bxos_pkg::ACT_LOAD: state_d = S_FETCH;
					bxos_pkg::ACT_PEEK: state_d = S_PEEK;
					bxos_pkg::ACT_SUM:  state_d = S_SUM;
					bxos_pkg::ACT_FIN:  state_d = S_DONE;
					default:            state_d = S_STEP;
				endcase
			end
			S_FETCH: begin
				cmd.latch = 1'b1;
				state_d   = S_STEP;
			end
			S_PEEK: begin
				cmd.peek = 1'b1;
				state_d  = (sts.act == bxos_pkg::ACT_LOAD) ? S_FETCH : S_STEP;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = (sts.act == bxos_pkg::ACT_FIN) ? S_DONE : S_FETCH;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ----- hdl/bxos_checker.sv -----
// ---------------------------------------------------------------------------
// bxos_checker: port-level checks for the trie block
// Watches the stream ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module bxos_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [111:0] s_tdata,
	input logic [2:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [79:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// One request at a time: the input closes right after taking a word.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input stayed open after a word was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output word changed");

	// A failed request reports no tally.
	a_fail_tally: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != bxos_pkg::ST_OK) |-> (m_tdata[55:32] == 24'd0))
		else $error("failed request carries a tally");

	// A rank at or beyond the size gives a zero value.
	a_rank_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == bxos_pkg::ST_RANK) |-> (m_tdata[31:0] == 32'd0))
		else $error("rank failure carries a value");

endmodule

bind binary_trie_xor_order_stats bxos_checker u_bxos_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
